@@ hdl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key table package
// Request, response and entry types plus operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [7:0]  type_code;
    logic [19:0] price;
  } skt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_type;
    logic [19:0] found_price;
    logic [4:0]  entry_count;
  } skt_rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  type_code;
    logic [19:0] price;
  } skt_entry_t;

  typedef struct packed {
    logic        capture;
    logic [15:0] key;
    logic        ins;
    logic        del;
    skt_entry_t  new_entry;
  } skt_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry, compares it against the request key and shifts with its
// neighbors on insert and delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
  input  wire                 clk,
  input  skt_pkg::skt_ctrl_t  ctrl,
  input  wire                 valid,
  input  skt_pkg::skt_entry_t left_entry,
  input  skt_pkg::skt_entry_t right_entry,
  input  wire                 left_lt,
  input  wire                 left_eq,
  output skt_pkg::skt_entry_t entry,
  output logic                lt,
  output logic                eq,
  output logic                hit
);
  import skt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt <= valid && (entry.key < ctrl.key);
      eq <= valid && (entry.key == ctrl.key);
    end
    if (ctrl.ins && !lt) begin
      entry <= left_lt ? ctrl.new_entry : left_entry;
    end else if (ctrl.del && !lt) begin
      entry <= right_entry;
    end
  end

  assign hit = eq && !left_eq;

endmodule

`default_nettype wire

@@ hdl/sorted_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted key table unit
// Table of entries kept in ascending key order with insert, find and delete.
// ----------------------------------------------------------------------------
// Each request is handled in a compare step and an execute step: in the cycle
// it is accepted every cell compares its key against the request key and
// registers the result; in the execute state the cells shift toward or away
// from the insert or delete position in one step and the response is loaded
// into the output register. A new request can be accepted while the previous
// response still waits; execution waits only if that register is still occupied.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_stall,
  input  skt_pkg::skt_req_t  req,
  output logic               rsp_valid,
  input  wire                rsp_stall,
  output skt_pkg::skt_rsp_t  rsp
);
  import skt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t          state;
  skt_req_t        cur;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  skt_rsp_t        rsp_next;
  skt_ctrl_t       ctrl;
  logic            exec_fire;
  logic            full;
  logic            found;
  logic [7:0]      found_type;
  logic [19:0]     found_price;

  skt_entry_t      entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;

  assign req_stall = (state == S_EXEC);
  assign exec_fire = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign full      = (count == CW'(TABLE_DEPTH));

  always_comb begin
    ctrl.capture   = (state == S_IDLE) && req_valid;
    ctrl.key       = req.key;
    ctrl.ins       = exec_fire && (cur.req_type == OP_INSERT) && !full;
    ctrl.del       = exec_fire && (cur.req_type == OP_DELETE) && found;
    ctrl.new_entry = '{key: cur.key, type_code: cur.type_code, price: cur.price};
  end

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    skt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (count > CW'(j)),
      .left_entry  ((j == 0) ? ctrl.new_entry : entries[(j == 0) ? 0 : j - 1]),
      .right_entry ((j == TABLE_DEPTH - 1) ? entries[j]
                                           : entries[(j == TABLE_DEPTH - 1) ? j : j + 1]),
      .left_lt     ((j == 0) ? 1'b1 : lt_vec[(j == 0) ? 0 : j - 1]),
      .left_eq     ((j == 0) ? 1'b0 : eq_vec[(j == 0) ? 0 : j - 1]),
      .entry       (entries[j]),
      .lt          (lt_vec[j]),
      .eq          (eq_vec[j]),
      .hit         (hit_vec[j])
    );
  end

  always_comb begin
    found_type  = '0;
    found_price = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      found_type  = found_type  | ({8{hit_vec[j]}}  & entries[j].type_code);
      found_price = found_price | ({20{hit_vec[j]}} & entries[j].price);
    end
  end

  assign found = |hit_vec;

  always_comb begin
    count_next           = count;
    rsp_next.status      = ST_OK;
    rsp_next.found_type  = '0;
    rsp_next.found_price = '0;
    case (cur.req_type)
      OP_INSERT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_FIND: begin
        if (found) begin
          rsp_next.found_type  = found_type;
          rsp_next.found_price = found_price;
        end else begin
          rsp_next.status = ST_MISSING;
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          rsp_next.status = ST_MISSING;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> full)
    else $error("table full reported while table has room");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("accepted request did not start execution");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.del |=> count == $past(count) - CW'(1))
    else $error("delete did not reduce entry count");

endmodule

`default_nettype wire

@@ dv/tb_sorted_key_table_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted key table unit testbench
// Drives insert, find and delete requests into the table and checks every
// response against an in-bench model of the sorted table. A short directed
// sequence covers the empty table, duplicate keys, a full table and the
// unused operation code. Random phases follow with both handshakes idling at
// random, a long output hold-off and a stretch with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;

  import skt_pkg::*;

  localparam int          TBL_DEPTH  = 16;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          HOLD_LEN   = 300;
  localparam int          QUIET_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  skt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  skt_rsp_t rsp;

  skt_req_t pending_reqs[$];
  skt_rsp_t expected_rsps[$];
  int       reqs_queued = 0;
  int       reqs_accepted = 0;
  int       err_count = 0;
  int       quiet_cycles = 0;
  logic     no_idle = 1'b0;
  int       hold_token = 0;
  int       hold_served = 0;
  int       hold_left = 0;

  logic [15:0] tbl_key[TBL_DEPTH];
  logic [7:0]  tbl_type[TBL_DEPTH];
  logic [19:0] tbl_price[TBL_DEPTH];
  int          tbl_count = 0;

  sorted_key_table_unit #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  function automatic skt_rsp_t table_apply(skt_req_t r);
    skt_rsp_t res;
    int       pos;
    res = '0;
    res.status = ST_OK;
    case (r.req_type)
      OP_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] < r.key) pos++;
          for (int j = tbl_count; j > pos; j--) begin
            tbl_key[j]   = tbl_key[j-1];
            tbl_type[j]  = tbl_type[j-1];
            tbl_price[j] = tbl_price[j-1];
          end
          tbl_key[pos]   = r.key;
          tbl_type[pos]  = r.type_code;
          tbl_price[pos] = r.price;
          tbl_count++;
        end
      end
      OP_FIND, OP_DELETE: begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] != r.key) pos++;
        if (pos >= tbl_count) begin
          res.status = ST_MISSING;
        end else if (r.req_type == OP_FIND) begin
          res.found_type  = tbl_type[pos];
          res.found_price = tbl_price[pos];
        end else begin
          for (int j = pos; j + 1 < tbl_count; j++) begin
            tbl_key[j]   = tbl_key[j+1];
            tbl_type[j]  = tbl_type[j+1];
            tbl_price[j] = tbl_price[j+1];
          end
          tbl_count--;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = tbl_count[4:0];
    return res;
  endfunction

  function automatic logic roll_idle();
    return !no_idle && ($urandom_range(99) < 25);
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(table_apply(req));
        reqs_accepted++;
      end
      if (req_valid && req_stall) begin
      end else if (pending_reqs.size() > 0 && !roll_idle()) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (hold_token != hold_served) begin
      hold_served = hold_token;
      hold_left   = HOLD_LEN;
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= roll_idle();
    end
  end

  always @(posedge clk) begin
    skt_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", 32'(rsp), 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.found_type !== want.found_type)
          report_mismatch("found_type", 32'(rsp.found_type), 32'(want.found_type));
        if (rsp.found_price !== want.found_price)
          report_mismatch("found_price", 32'(rsp.found_price), 32'(want.found_price));
        if (rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(logic [1:0] op, logic [15:0] k, logic [7:0] t, logic [19:0] p);
    skt_req_t r;
    r.req_type  = op;
    r.key       = k;
    r.type_code = t;
    r.price     = p;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic queue_random(int n, int insert_pct);
    logic [1:0]  op;
    logic [15:0] k;
    int          pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 2) begin
        op = OP_UNUSED;
      end else if ($urandom_range(99) < insert_pct) begin
        op = OP_INSERT;
      end else begin
        op = $urandom_range(1) ? OP_FIND : OP_DELETE;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        k = 16'($urandom_range(23));
      end else if (pick < 80) begin
        k = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end else begin
        k = 16'($urandom);
      end
      queue_req(op, k, 8'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_req(OP_FIND, 16'h0000, 8'hFF, 20'hFFFFF);
    queue_req(OP_DELETE, 16'hFFFF, 8'h00, 20'h00000);
    queue_req(OP_UNUSED, 16'hFFFF, 8'hFF, 20'hFFFFF);
    queue_req(OP_INSERT, 16'hFFFF, 8'hFF, 20'hFFFFF);
    queue_req(OP_INSERT, 16'h0000, 8'h00, 20'h00000);
    queue_req(OP_INSERT, 16'hFFFF, 8'h5A, 20'hA5A5A);
    queue_req(OP_FIND, 16'hFFFF, 8'h00, 20'h00000);
    queue_req(OP_DELETE, 16'hFFFF, 8'h00, 20'h00000);
    queue_req(OP_FIND, 16'hFFFF, 8'h00, 20'h00000);
    queue_req(OP_FIND, 16'h0000, 8'hFF, 20'hFFFFF);
    for (int i = 0; i < TBL_DEPTH - 2; i++) begin
      queue_req(OP_INSERT, 16'h1000 + 16'(i * 16'h0111), 8'($urandom), 20'($urandom));
    end
    queue_req(OP_INSERT, 16'h8000, 8'hFF, 20'hFFFFF);
    wait_drained();

    queue_random(300, 50);
    wait_drained();

    // Hold the output off while requests keep coming so the table backs up.
    hold_token++;
    queue_random(300, 70);
    wait_drained();

    no_idle = 1'b1;
    queue_random(300, 40);
    wait_drained();
    no_idle = 1'b0;

    queue_random(350, 50);
    wait_drained();

    repeat (10) @(negedge clk);
    if (expected_rsps.size() != 0)
      report_mismatch("responses missing", 0, expected_rsps.size());
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
